### rtl/core/sml_pkg.sv
// ----------------------------------------------------------------------------
// sml_pkg
// Shared types and constants for the structure member layout unit.
// ----------------------------------------------------------------------------
package sml_pkg;

  // size limit and unit geometry
  localparam int MAX_STRUCT_BYTES = 65536;
  localparam int UNIT_BITS        = 32;
  localparam int UNIT_LOG2        = $clog2(UNIT_BITS);
  localparam int POS_W            = 20;
  localparam int POS_MAX          = (2 ** POS_W) - 1;
  localparam int LIMIT_BITS       = (MAX_STRUCT_BYTES * 8 > POS_MAX) ? POS_MAX
                                                                    : MAX_STRUCT_BYTES * 8;
  // room for a position plus a rounding or a member size
  localparam int SUM_W            = POS_W + 2;
  localparam int ALIGN_W          = 10;
  localparam int MAX_ALIGN_LOG2   = 6;

  // op codes
  localparam logic [1:0] OP_PLAIN    = 2'd0;
  localparam logic [1:0] OP_BITFIELD = 2'd1;
  localparam logic [1:0] OP_END      = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] member_size;
    logic [2:0]  align_log2;
    logic [5:0]  field_width;
  } item_t;

  typedef struct packed {
    logic [16:0] byte_offset;
    logic [4:0]  bit_in_unit;
    logic [6:0]  struct_align;
    logic        is_total;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0]   bit_position;
    logic [ALIGN_W-1:0] max_align_bits;
    logic               overflowed;
  } layout_state_t;

endpackage

### rtl/core/sml_in_if.sv
// ----------------------------------------------------------------------------
// sml_in_if
// Valid/ready channel carrying one structure member or end word.
// ----------------------------------------------------------------------------
interface sml_in_if;
  logic          valid;
  logic          ready;
  sml_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sml_out_if.sv
// ----------------------------------------------------------------------------
// sml_out_if
// Valid/ready channel carrying one layout result word.
// ----------------------------------------------------------------------------
interface sml_out_if;
  logic            valid;
  logic            ready;
  sml_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sml_step.sv
// ----------------------------------------------------------------------------
// sml_step
// Layout arithmetic for one word: aligns, packs bitfields, saturates at the
// size limit and forms the next state and the result.
// ----------------------------------------------------------------------------
module sml_step (
  input  sml_pkg::item_t         item,
  input  sml_pkg::layout_state_t cur,
  output sml_pkg::layout_state_t nxt,
  output sml_pkg::result_t       res
);
  import sml_pkg::*;

  localparam logic [SUM_W-1:0] LIM       = SUM_W'(LIMIT_BITS);
  localparam logic [SUM_W-1:0] UNIT_MASK = SUM_W'(UNIT_BITS - 1);

  function automatic logic [SUM_W-1:0] clamp(input logic [SUM_W-1:0] p);
    return (p > LIM) ? LIM : p;
  endfunction

  logic [SUM_W-1:0]   pos_w;
  // plain member
  logic [2:0]         alog_c;
  logic [ALIGN_W-1:0] pl_align;
  logic [SUM_W-1:0]   pl_mask, pl_up, pl_start, pl_sum, pl_end;
  logic               pl_hit1, pl_hit2;
  // bitfield
  logic [SUM_W-1:0]   unit_up, bf_raw, bf_start, bf_sum, bf_end;
  logic [5:0]         bw_c;
  logic               bf_zero, straddle, bf_hit1, bf_hit2;
  // end of structure
  logic               en_empty, en_hit;
  logic [ALIGN_W-1:0] en_align;
  logic [SUM_W-1:0]   en_base, en_mask, en_up, en_tot;

  assign pos_w = SUM_W'(cur.bit_position);

  assign alog_c   = (item.align_log2 > 3'(MAX_ALIGN_LOG2)) ? 3'(MAX_ALIGN_LOG2)
                                                            : item.align_log2;
  assign pl_align = ALIGN_W'(8) << alog_c;
  assign pl_mask  = SUM_W'(pl_align) - SUM_W'(1);
  assign pl_up    = (pos_w + pl_mask) & ~pl_mask;
  assign pl_hit1  = pl_up > LIM;
  assign pl_start = clamp(pl_up);
  assign pl_sum   = pl_start + SUM_W'({item.member_size, 3'b000});
  assign pl_hit2  = pl_sum > LIM;
  assign pl_end   = clamp(pl_sum);

  assign unit_up  = (pos_w + UNIT_MASK) & ~UNIT_MASK;
  assign bw_c     = (item.field_width > 6'(UNIT_BITS)) ? 6'(UNIT_BITS) : item.field_width;
  assign bf_zero  = (item.field_width == 6'd0);
  // field would cross into the next unit
  assign straddle = (7'(cur.bit_position[UNIT_LOG2-1:0]) + 7'(bw_c)) > 7'(UNIT_BITS);
  assign bf_raw   = (bf_zero || straddle) ? unit_up : pos_w;
  assign bf_hit1  = bf_raw > LIM;
  assign bf_start = clamp(bf_raw);
  assign bf_sum   = bf_start + SUM_W'(bw_c);
  assign bf_hit2  = bf_sum > LIM;
  assign bf_end   = clamp(bf_sum);

  // empty structure reports one unit of size and alignment
  assign en_empty = (cur.max_align_bits == '0);
  assign en_align = en_empty ? ALIGN_W'(UNIT_BITS) : cur.max_align_bits;
  assign en_base  = en_empty ? SUM_W'(UNIT_BITS) : pos_w;
  assign en_mask  = SUM_W'(en_align) - SUM_W'(1);
  assign en_up    = (en_base + en_mask) & ~en_mask;
  assign en_hit   = en_up > LIM;
  assign en_tot   = clamp(en_up);

  always_comb begin
    nxt          = cur;
    res          = '0;
    res.overflow = cur.overflowed;
    case (item.op)
      OP_PLAIN: begin
        nxt.overflowed   = cur.overflowed | pl_hit1 | pl_hit2;
        nxt.bit_position = pl_end[POS_W-1:0];
        if (pl_align > cur.max_align_bits) begin
          nxt.max_align_bits = pl_align;
        end
        res.byte_offset = 17'(pl_start >> 3);
        res.overflow    = nxt.overflowed;
      end
      OP_BITFIELD: begin
        res.byte_offset = 17'((bf_start >> UNIT_LOG2) << (UNIT_LOG2 - 3));
        if (bf_zero) begin
          nxt.overflowed   = cur.overflowed | bf_hit1;
          nxt.bit_position = bf_start[POS_W-1:0];
        end else begin
          nxt.overflowed   = cur.overflowed | bf_hit1 | bf_hit2;
          nxt.bit_position = bf_end[POS_W-1:0];
          res.bit_in_unit  = 5'(bf_start[UNIT_LOG2-1:0]);
          if (ALIGN_W'(UNIT_BITS) > cur.max_align_bits) begin
            nxt.max_align_bits = ALIGN_W'(UNIT_BITS);
          end
        end
        res.overflow = nxt.overflowed;
      end
      OP_END: begin
        res.byte_offset  = 17'(en_tot >> 3);
        res.struct_align = 7'(en_align >> 3);
        res.is_total     = 1'b1;
        res.overflow     = cur.overflowed | en_hit;
        nxt              = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

### rtl/core/struct_member_layout_unit.sv
// ----------------------------------------------------------------------------
// struct_member_layout_unit
// Lays out the members of a structure one word at a time.
// ----------------------------------------------------------------------------
// Channels: item (sink) takes one member word per cycle while result.ready is
// high: a plain member with its size and alignment, a bitfield with its width,
// or an end word. result (source) gives exactly one word for each item: the
// member's byte offset (and bit offset for bitfields), or on an end word the
// total size and alignment, with a sticky overflow flag.
// Path: an accepted word goes into the input register, then its result into
// the result register, where result.valid rises. Throughput: one word per
// cycle while result.ready is high, set by the single add, mask and compare
// chain on the running position between the two registers.
// Reset: rst clears the running position, alignment and overflow flag and
// empties both registers. An end word clears the same state after reporting.
// Stall: while result.ready is low the result word holds; one more word is
// held in the input register, then item.ready drops until the result drains.
// ----------------------------------------------------------------------------
module struct_member_layout_unit (
  input logic      clk,
  input logic      rst,
  sml_in_if.sink   item,
  sml_out_if.source result
);
  import sml_pkg::*;

  item_t         stage;
  logic          stage_valid;
  layout_state_t state;
  layout_state_t state_next;
  result_t       res_next;
  result_t       res_q;
  logic          res_valid;
  logic          advance;

  assign advance    = stage_valid && (!res_valid || result.ready);
  assign item.ready = !stage_valid || advance;

  sml_step u_step (
    .item (stage),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
      state       <= '0;
    end else begin
      if (item.ready) begin
        stage_valid <= item.valid;
      end
      if (advance) begin
        state     <= state_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage <= item.data;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_q;

`ifndef NO_ASSERTIONS
  // an end word leaves the layout state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (stage.op == OP_END) |=> (state == '0))
    else $error("state not cleared after end word");

  // running position never passes the size limit
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    32'(state.bit_position) <= 32'(LIMIT_BITS))
    else $error("bit position beyond limit");

  // a total reports a power-of-two alignment, other words none
  a_total_align: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.is_total |-> $onehot(result.data.struct_align))
    else $error("total without a valid alignment");

  a_member_align: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.is_total |-> (result.data.struct_align == '0))
    else $error("member word carries an alignment");
`endif

endmodule
